>>> rtl/srbd_pkg.sv
// Shared types and constants for the shape record bitstream decoder.
// No dependencies.
`timescale 1ns / 1ps

package srbd_pkg;

  localparam int unsigned DeltaW = 31;
  localparam int unsigned AnchW  = 17;
  localparam int unsigned IdxW   = 15;
  localparam int unsigned QDepth = 4;

  typedef enum logic [2:0] {
    KIND_END   = 3'd0,
    KIND_STYLE = 3'd1,
    KIND_EDGE  = 3'd2,
    KIND_CURVE = 3'd3,
    KIND_NEWST = 3'd4
  } kind_e;

  typedef struct packed {
    logic [2:0]               kind;
    logic [3:0]               mask;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
    logic signed [AnchW-1:0]  ax;
    logic signed [AnchW-1:0]  ay;
    logic [IdxW-1:0]          f0;
    logic [IdxW-1:0]          f1;
    logic [IdxW-1:0]          ln;
    logic                     last;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t data;
  } push_t;

endpackage

>>> rtl/srbd_outq.sv
// Four-entry result queue between the parser and the output channel.
// Depends on srbd_pkg.
`timescale 1ns / 1ps

module srbd_outq import srbd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  valid_o,
  input  logic  pop_i,
  output res_t  data_o
);

  res_t       mem_q [QDepth];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       do_pop;

  assign valid_o = (cnt_q != 3'd0);
  assign do_pop  = valid_o && pop_i;
  assign room_o  = (cnt_q <= 3'd2);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.valid) wr_q <= wr_q + 2'd1;
      if (do_pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, push_i.valid} - {2'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) mem_q[wr_q] <= push_i.data;
  end

endmodule

>>> rtl/srbd_parser.sv
// Bit-serial record parser: one stream bit or one zero-width field per cycle
// through a shared accumulator. Depends on srbd_pkg.
`timescale 1ns / 1ps

module srbd_parser import srbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  logic [7:0] byte_i,
  input  logic       start_i,
  output logic       busy_o,
  output push_t      push_o
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_TYPE, PH_FLAGS, PH_MBITS, PH_MX, PH_MY, PH_F0, PH_F1, PH_LN,
    PH_STR, PH_NB, PH_GEN, PH_VERT, PH_DX, PH_DY, PH_CX, PH_CY, PH_AX, PH_AY
  } phase_e;

  typedef enum logic [1:0] {SQ_IDLE, SQ_RUN, SQ_FLUSH} seq_e;

  typedef struct packed {
    phase_e     ph;
    logic [4:0] w;
    logic       emit;
    logic [2:0] kind;
  } next_t;

  seq_e                     seq_q, seq_d;
  phase_e                   ph_q, ph_d;
  logic [3:0]               fw_q, fw_d, lw_q, lw_d;
  logic [4:0]               rem_q, rem_d, emw_q, emw_d;
  logic [5:0]               flg_q, flg_d;
  logic [DeltaW-1:0]        acc_q, acc_d;
  logic                     first_q, first_d;
  logic [7:0]               sh_q, sh_d;
  logic [3:0]               cnt_q, cnt_d;
  logic [1:0]               ecnt_q, ecnt_d;
  logic signed [DeltaW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [AnchW-1:0]  ax_q, ax_d, ay_q, ay_d;
  logic [IdxW-1:0]          f0_q, f0_d, f1_q, f1_d, ln_q, ln_d;
  res_t                     pend_q, pend_d;
  logic                     pv_q, pv_d;

  logic              do_fin, sgn, bit_in;
  logic [DeltaW-1:0] v, base;
  next_t             nx;
  res_t              newr;

  function automatic next_t style_after(input logic [2:0] stage, input logic [5:0] f,
                                        input logic [3:0] fw, input logic [3:0] lw);
    next_t r;
    r = '{ph: PH_TYPE, w: 5'd1, emit: 1'b0, kind: KIND_STYLE};
    if (stage == 3'd0 && f[0]) begin
      r.ph = PH_MBITS; r.w = 5'd5;
    end else if (stage <= 3'd1 && f[1]) begin
      r.ph = PH_F0; r.w = {1'b0, fw};
    end else if (stage <= 3'd2 && f[2]) begin
      r.ph = PH_F1; r.w = {1'b0, fw};
    end else if (stage <= 3'd3 && f[3]) begin
      r.ph = PH_LN; r.w = {1'b0, lw};
    end else if (f[4]) begin
      r = '{ph: PH_IDLE, w: 5'd0, emit: 1'b1, kind: KIND_NEWST};
    end else if (f[4:0] == 5'd0) begin
      r = '{ph: PH_IDLE, w: 5'd0, emit: 1'b1, kind: KIND_END};
    end else begin
      r.emit = 1'b1;
    end
    return r;
  endfunction

  assign busy_o = (seq_q != SQ_IDLE);
  assign bit_in = sh_q[7];
  assign sgn = (ph_q == PH_MX) || (ph_q == PH_MY) || (ph_q == PH_DX) || (ph_q == PH_DY) ||
               (ph_q == PH_CX) || (ph_q == PH_CY) || (ph_q == PH_AX) || (ph_q == PH_AY);

  always_comb begin
    seq_d = seq_q; ph_d = ph_q; fw_d = fw_q; lw_d = lw_q; rem_d = rem_q; emw_d = emw_q;
    flg_d = flg_q; acc_d = acc_q; first_d = first_q; sh_d = sh_q; cnt_d = cnt_q;
    ecnt_d = ecnt_q; dx_d = dx_q; dy_d = dy_q; ax_d = ax_q; ay_d = ay_q;
    f0_d = f0_q; f1_d = f1_q; ln_d = ln_q; pend_d = pend_q; pv_d = pv_q;
    push_o = '0;
    do_fin = 1'b0;
    v = '0;
    nx = '{ph: PH_IDLE, w: 5'd0, emit: 1'b0, kind: KIND_END};
    newr = '0;
    base = first_q ? {DeltaW{sgn & bit_in}} : acc_q;

    unique case (seq_q)
      SQ_IDLE: begin
        if (load_i) begin
          if (start_i) begin
            fw_d = byte_i[7:4]; lw_d = byte_i[3:0];
            emw_d = '0; flg_d = '0;
            dx_d = '0; dy_d = '0; ax_d = '0; ay_d = '0; f0_d = '0; f1_d = '0; ln_d = '0;
            ph_d = PH_TYPE; rem_d = 5'd1; first_d = 1'b1;
          end else begin
            sh_d = byte_i; cnt_d = '0; ecnt_d = '0; seq_d = SQ_RUN;
          end
        end
      end
      SQ_RUN: begin
        if (ph_q != PH_IDLE && rem_q == 5'd0) begin
          do_fin = 1'b1;
        end else if (cnt_q == 4'd8) begin
          seq_d = SQ_FLUSH;
        end else begin
          sh_d = {sh_q[6:0], 1'b0};
          cnt_d = cnt_q + 4'd1;
          if (ph_q != PH_IDLE) begin
            acc_d = {base[DeltaW-2:0], bit_in};
            first_d = 1'b0;
            rem_d = rem_q - 5'd1;
            if (rem_q == 5'd1) begin
              do_fin = 1'b1;
              v = acc_d;
            end
          end
        end
      end
      SQ_FLUSH: begin
        if (pv_q) begin
          push_o.valid = 1'b1;
          push_o.data = pend_q;
          push_o.data.last = 1'b1;
        end
        pv_d = 1'b0;
        seq_d = SQ_IDLE;
      end
      default: seq_d = SQ_IDLE;
    endcase

    if (do_fin) begin
      unique case (ph_q)
        PH_TYPE: begin
          dx_d = '0; dy_d = '0; ax_d = '0; ay_d = '0; f0_d = '0; f1_d = '0; ln_d = '0;
          if (v[0]) begin
            flg_d = 6'h20; nx.ph = PH_STR; nx.w = 5'd1;
          end else begin
            flg_d = '0; nx.ph = PH_FLAGS; nx.w = 5'd5;
          end
        end
        PH_FLAGS: begin
          flg_d = {1'b0, v[4:0]};
          nx = style_after(3'd0, flg_d, fw_q, lw_q);
        end
        PH_MBITS: begin
          emw_d = v[4:0]; nx.ph = PH_MX; nx.w = v[4:0];
        end
        PH_MX: begin
          dx_d = v; nx.ph = PH_MY; nx.w = emw_q;
        end
        PH_MY: begin
          dy_d = v; nx = style_after(3'd1, flg_q, fw_q, lw_q);
        end
        PH_F0: begin
          f0_d = v[IdxW-1:0]; nx = style_after(3'd2, flg_q, fw_q, lw_q);
        end
        PH_F1: begin
          f1_d = v[IdxW-1:0]; nx = style_after(3'd3, flg_q, fw_q, lw_q);
        end
        PH_LN: begin
          ln_d = v[IdxW-1:0]; nx = style_after(3'd4, flg_q, fw_q, lw_q);
        end
        PH_STR: begin
          if (v[0]) flg_d[0] = 1'b1;
          nx.ph = PH_NB; nx.w = 5'd4;
        end
        PH_NB: begin
          emw_d = {1'b0, v[3:0]} + 5'd2;
          if (flg_q[0]) begin
            nx.ph = PH_GEN; nx.w = 5'd1;
          end else begin
            nx.ph = PH_CX; nx.w = emw_d;
          end
        end
        PH_GEN: begin
          if (v[0]) begin
            flg_d[1] = 1'b1; nx.ph = PH_DX;
          end else begin
            nx.ph = PH_VERT;
          end
          nx.w = v[0] ? emw_q : 5'd1;
        end
        PH_VERT: begin
          if (v[0]) begin
            flg_d[2] = 1'b1; nx.ph = PH_DY;
          end else begin
            nx.ph = PH_DX;
          end
          nx.w = emw_q;
        end
        PH_DX: begin
          dx_d = v;
          if (flg_q[1]) begin
            nx.ph = PH_DY; nx.w = emw_q;
          end else begin
            nx = '{ph: PH_TYPE, w: 5'd1, emit: 1'b1, kind: KIND_EDGE};
          end
        end
        PH_DY: begin
          dy_d = v; nx = '{ph: PH_TYPE, w: 5'd1, emit: 1'b1, kind: KIND_EDGE};
        end
        PH_CX: begin
          dx_d = v; nx.ph = PH_CY; nx.w = emw_q;
        end
        PH_CY: begin
          dy_d = v; nx.ph = PH_AX; nx.w = emw_q;
        end
        PH_AX: begin
          ax_d = v[AnchW-1:0]; nx.ph = PH_AY; nx.w = emw_q;
        end
        PH_AY: begin
          ay_d = v[AnchW-1:0]; nx = '{ph: PH_TYPE, w: 5'd1, emit: 1'b1, kind: KIND_CURVE};
        end
        default: nx.ph = PH_IDLE;
      endcase
      ph_d = nx.ph;
      rem_d = nx.w;
      first_d = 1'b1;

      if (nx.emit && ecnt_q != 2'd2) begin
        newr.kind = nx.kind;
        newr.mask = (nx.kind == KIND_STYLE || nx.kind == KIND_NEWST) ? flg_d[3:0] : 4'd0;
        newr.dx = dx_d; newr.dy = dy_d; newr.ax = ax_d; newr.ay = ay_d;
        newr.f0 = f0_d; newr.f1 = f1_d; newr.ln = ln_d;
        newr.last = 1'b0;
        if (pv_q) begin
          push_o.valid = 1'b1;
          push_o.data = pend_q;
        end
        pend_d = newr;
        pv_d = 1'b1;
        ecnt_d = ecnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SQ_IDLE; ph_q <= PH_IDLE; fw_q <= '0; lw_q <= '0; rem_q <= '0;
      emw_q <= '0; flg_q <= '0; acc_q <= '0; first_q <= 1'b0; cnt_q <= '0;
      ecnt_q <= '0; pv_q <= 1'b0;
      dx_q <= '0; dy_q <= '0; ax_q <= '0; ay_q <= '0; f0_q <= '0; f1_q <= '0; ln_q <= '0;
    end else begin
      seq_q <= seq_d; ph_q <= ph_d; fw_q <= fw_d; lw_q <= lw_d; rem_q <= rem_d;
      emw_q <= emw_d; flg_q <= flg_d; acc_q <= acc_d; first_q <= first_d; cnt_q <= cnt_d;
      ecnt_q <= ecnt_d; pv_q <= pv_d;
      dx_q <= dx_d; dy_q <= dy_d; ax_q <= ax_d; ay_q <= ay_d; f0_q <= f0_d; f1_q <= f1_d;
      ln_q <= ln_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    pend_q <= pend_d;
  end

endmodule

>>> rtl/shape_record_bitstream_decoder_core.sv
// Top level of the shape record bitstream decoder: handshake glue around
// the bit-serial parser and the result queue. Depends on srbd_pkg.
`timescale 1ns / 1ps

// Usage:
//  Input channel (in_valid_i / in_stall_o) carries one stream word per
//  handshake: data_byte_i and shape_start_i. A word with shape_start_i set
//  loads the fill and line index widths (high and low nibble) and restarts
//  parsing at a record boundary; it gives no result.
//  Any other word is parsed MSB first, one bit per cycle through the shared
//  accumulator, with a turn of its own for every zero-width field that
//  closes within the word (up to eight); then the bit count ends, the last
//  result is handed over and the parser returns to idle before it takes
//  the next word. in_stall_o is high while a word is being parsed and
//  while the result queue has fewer than two free entries.
//  Output channel (out_valid_o / out_stall_i) gives up to two result words
//  per input word; last_of_byte_o marks the final one of a word. Results
//  sit in a four-entry queue, so a stalled receiver holds the current word
//  steady while words are still taken until fewer than two entries are free.
//  Each result waits in the parser until the next record of the word
//  completes or the word's bit count ends, then enters the queue.
//  Reset (rst_ni low, asynchronous) empties the queue, clears the widths
//  and parses nothing until a word with shape_start_i arrives.

module shape_record_bitstream_decoder_core import srbd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     shape_start_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               record_kind_o,
  output logic [3:0]               present_mask_o,
  output logic signed [DeltaW-1:0] delta_x_o,
  output logic signed [DeltaW-1:0] delta_y_o,
  output logic signed [AnchW-1:0]  anchor_dx_o,
  output logic signed [AnchW-1:0]  anchor_dy_o,
  output logic [IdxW-1:0]          fill0_index_o,
  output logic [IdxW-1:0]          fill1_index_o,
  output logic [IdxW-1:0]          line_index_o,
  output logic                     last_of_byte_o
);

  logic  busy, room, load;
  push_t push;
  res_t  head;

  // Accept only when the parser is idle and the queue can absorb a full word.
  assign in_stall_o = busy || !room;
  assign load       = in_valid_i && !in_stall_o;

  srbd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .byte_i (data_byte_i),
    .start_i(shape_start_i),
    .busy_o (busy),
    .push_o (push)
  );

  srbd_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .valid_o(out_valid_o),
    .pop_i  (!out_stall_i),
    .data_o (head)
  );

  assign record_kind_o  = head.kind;
  assign present_mask_o = head.mask;
  assign delta_x_o      = head.dx;
  assign delta_y_o      = head.dy;
  assign anchor_dx_o    = head.ax;
  assign anchor_dy_o    = head.ay;
  assign fill0_index_o  = head.f0;
  assign fill1_index_o  = head.f1;
  assign line_index_o   = head.ln;
  assign last_of_byte_o = head.last;

endmodule

>>> rtl/srbd_checker.sv
// Port-level checks for the shape record bitstream decoder, bound to the
// top level. Depends on srbd_pkg.
`timescale 1ns / 1ps

module srbd_props import srbd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       shape_start_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] record_kind_o,
  input logic [3:0] present_mask_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(record_kind_o) && $stable(present_mask_o))
    else $error("stalled output word changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !shape_start_i |=> in_stall_o)
    else $error("data word accepted without a parse interval");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> record_kind_o <= KIND_NEWST)
    else $error("record kind out of range");

  a_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o != KIND_STYLE && record_kind_o != KIND_NEWST
      |-> present_mask_o == 4'd0)
    else $error("present mask set on a non-style record");

endmodule

bind shape_record_bitstream_decoder_core srbd_props u_srbd_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .shape_start_i (shape_start_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .record_kind_o (record_kind_o),
  .present_mask_o(present_mask_o)
);
